// ----- hdl/mouse_click_drag_detector_core_defines.svh -----
// assertion macros for the mouse click / drag detector core
// expects i_clk and i_rst_n in the scope that uses them
`ifndef MOUSE_CLICK_DRAG_DETECTOR_CORE_DEFINES_SVH
`define MOUSE_CLICK_DRAG_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define MCDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCDD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mcdd_pkg.sv -----
// shared types, constants and helpers of the click / drag detector
// used by mcdd_cfg, mcdd_ctrl, mcdd_dp and the top level
package mcdd_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int BUTTON_COUNT_DEF  = 3;

    localparam int POS_W      = 16;
    localparam int VEC_W      = 17;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DIST_W     = 7;
    localparam int DIST2_W    = 14;
    localparam int WIN_CFG_W  = 5;
    localparam int RPT_W      = 2;
    localparam int SQ_W       = 32;
    localparam int LEN2_W     = 33;
    localparam int WIN_MIN    = 2;

    localparam logic [DIST_W-1:0]    DIST_MAX   = 7'd100;
    localparam logic [DIST_W-1:0]    THR_RESET  = 7'd20;
    localparam logic [DIST_W-1:0]    DCD_RESET  = 7'd20;
    localparam logic [WIN_CFG_W-1:0] WIN_RESET  = 5'd10;
    localparam logic [RPT_W-1:0]     RPT_RESET  = 2'd0;
    localparam logic [RPT_W-1:0]     RPT_NONE   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_WIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_BTN  = 2'd3;

    typedef struct packed {
        logic [DIST2_W-1:0] thr2;
        logic [DIST2_W-1:0] dcd2;
        logic [RPT_W-1:0]   rpt;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic vec;
        logic sq;
        logic eval;
        logic scan;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic sq_done;
        logic scan_more;
        logic out_free;
    } t_sts;

    // squared distance, saturated to the largest legal distance first
    function automatic logic [DIST2_W-1:0] dist_sq(input logic [DIST_W-1:0] d);
        logic [DIST_W-1:0]  s;
        logic [DIST2_W-1:0] w;
        s = (d > DIST_MAX) ? DIST_MAX : d;
        w = DIST2_W'(s);
        return w * w;
    endfunction

endpackage

// ----- hdl/mouse_click_drag_detector_core.sv -----
// mouse click / drag / double click detector, top level
// instantiates mcdd_cfg, mcdd_ctrl, mcdd_dp; uses mcdd_pkg and the defines header
//
// One request per frame on the input channel (i_in_valid / o_in_ready): cursor
// position and button bits. One result per request on the output channel
// (o_out_valid / i_out_ready): held, pressed, released, dragging, clicked and
// double-clicked masks plus the drag vector of the selected button.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// A request is worked on one at a time, from accept through the vector update,
// the squaring, the evaluation, the history scan and the final load of the
// result register. The pace is set by the single squarer shared over both axes
// of every button and by the history scan, which reads one entry of the history
// memory per cycle.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and worked on, and waits only at the final load.
// Synchronous reset restores the register defaults, empties the history (a
// fill count marks unwritten entries as released) and clears the drag flags.
`include "mouse_click_drag_detector_core_defines.svh"

module mouse_click_drag_detector_core #(
    parameter int HISTORY_DEPTH = mcdd_pkg::HISTORY_DEPTH_DEF,
    parameter int BUTTON_COUNT  = mcdd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mcdd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mcdd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [mcdd_pkg::POS_W-1:0]     i_cursor_x,
    input  logic signed [mcdd_pkg::POS_W-1:0]     i_cursor_y,
    input  logic [mcdd_pkg::MASK_W-1:0]           i_button_bits,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [mcdd_pkg::MASK_W-1:0]           o_held_mask,
    output logic [mcdd_pkg::MASK_W-1:0]           o_pressed_mask,
    output logic [mcdd_pkg::MASK_W-1:0]           o_released_mask,
    output logic [mcdd_pkg::MASK_W-1:0]           o_dragging_mask,
    output logic [mcdd_pkg::MASK_W-1:0]           o_clicked_mask,
    output logic [mcdd_pkg::MASK_W-1:0]           o_double_clicked_mask,
    output logic signed [mcdd_pkg::VEC_W-1:0]     o_drag_dx,
    output logic signed [mcdd_pkg::VEC_W-1:0]     o_drag_dy
);

    mcdd_pkg::t_cfg                       w_cfg;
    logic [$clog2(HISTORY_DEPTH+1)-1:0]   w_win;
    mcdd_pkg::t_cmd                       w_cmd;
    mcdd_pkg::t_sts                       w_sts;

    mcdd_cfg #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_win      (w_win)
    );

    mcdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mcdd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .BUTTON_COUNT  (BUTTON_COUNT)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_sts                 (w_sts),
        .i_cfg                 (w_cfg),
        .i_win                 (w_win),
        .i_cursor_x            (i_cursor_x),
        .i_cursor_y            (i_cursor_y),
        .i_button_bits         (i_button_bits),
        .i_out_ready           (i_out_ready),
        .o_out_valid           (o_out_valid),
        .o_held_mask           (o_held_mask),
        .o_pressed_mask        (o_pressed_mask),
        .o_released_mask       (o_released_mask),
        .o_dragging_mask       (o_dragging_mask),
        .o_clicked_mask        (o_clicked_mask),
        .o_double_clicked_mask (o_double_clicked_mask),
        .o_drag_dx             (o_drag_dx),
        .o_drag_dy             (o_drag_dy)
    );

    // a request in work blocks the next one
    `MCDD_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    // a result shows up only from the final step
    `MCDD_ASSERT_IMP(a_out_from_fin, $rose(o_out_valid), $past(w_cmd.fin), "result without final step")
    // clicks come from releases and double clicks are clicks
    `MCDD_ASSERT_IMP(a_click_on_release, o_out_valid, ((o_clicked_mask & ~o_released_mask) == '0) && ((o_double_clicked_mask & ~o_clicked_mask) == '0), "click mask mismatch")
    // a dragged button never reports a click
    `MCDD_ASSERT_IMP(a_drag_no_click, o_out_valid, (o_dragging_mask & o_clicked_mask) == '0, "drag and click together")

endmodule

// ----- hdl/mcdd_cfg.sv -----
// configuration registers: squared distances, scan window, reported button
// depends on mcdd_pkg
module mcdd_cfg #(
    parameter int HISTORY_DEPTH = mcdd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcdd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcdd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mcdd_pkg::t_cfg                      o_cfg,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]  o_win
);

    localparam int WIN_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [WIN_W-1:0] WIN_RST =
        WIN_W'((int'(mcdd_pkg::WIN_RESET) > HISTORY_DEPTH) ?
               HISTORY_DEPTH : int'(mcdd_pkg::WIN_RESET));

    mcdd_pkg::t_cfg   r_cfg;
    logic [WIN_W-1:0] r_win, n_win;

    // window clamped into the range the history can serve
    always_comb begin
        if (int'(i_cfg_data[mcdd_pkg::WIN_CFG_W-1:0]) < mcdd_pkg::WIN_MIN) begin
            n_win = WIN_W'(mcdd_pkg::WIN_MIN);
        end else if (int'(i_cfg_data[mcdd_pkg::WIN_CFG_W-1:0]) > HISTORY_DEPTH) begin
            n_win = WIN_W'(HISTORY_DEPTH);
        end else begin
            n_win = WIN_W'(i_cfg_data[mcdd_pkg::WIN_CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr2 <= mcdd_pkg::dist_sq(mcdd_pkg::THR_RESET);
            r_cfg.dcd2 <= mcdd_pkg::dist_sq(mcdd_pkg::DCD_RESET);
            r_cfg.rpt  <= mcdd_pkg::RPT_RESET;
            r_win      <= WIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcdd_pkg::CFG_DRAG_THR: begin
                    r_cfg.thr2 <= mcdd_pkg::dist_sq(i_cfg_data[mcdd_pkg::DIST_W-1:0]);
                end
                mcdd_pkg::CFG_DC_DIST: begin
                    r_cfg.dcd2 <= mcdd_pkg::dist_sq(i_cfg_data[mcdd_pkg::DIST_W-1:0]);
                end
                mcdd_pkg::CFG_DC_WIN: begin
                    r_win <= n_win;
                end
                mcdd_pkg::CFG_RPT_BTN: begin
                    r_cfg.rpt <= i_cfg_data[mcdd_pkg::RPT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
    assign o_win = r_win;

endmodule

// ----- hdl/mcdd_ctrl.sv -----
// sequencer: walks one request through vector update, squaring, evaluation, scan, result
// depends on mcdd_pkg
module mcdd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mcdd_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output mcdd_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VEC,
        S_SQR,
        S_EVAL,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_VEC;
                end
            end
            S_VEC: begin
                o_cmd.vec = 1'b1;
                n_state   = S_SQR;
            end
            S_SQR: begin
                o_cmd.sq = 1'b1;
                if (i_sts.sq_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                // last history read is consumed in the cycle scan_more drops
                o_cmd.scan = 1'b1;
                if (!i_sts.scan_more) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ----- hdl/mcdd_dp.sv -----
// datapath: button history memory, per-button drag vectors, shared squarer,
// press/release/press recognizers and the result register; depends on mcdd_pkg
module mcdd_dp #(
    parameter int HISTORY_DEPTH = mcdd_pkg::HISTORY_DEPTH_DEF,
    parameter int BUTTON_COUNT  = mcdd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mcdd_pkg::t_cmd                           i_cmd,
    output mcdd_pkg::t_sts                           o_sts,
    input  mcdd_pkg::t_cfg                           i_cfg,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]       i_win,
    input  logic signed [mcdd_pkg::POS_W-1:0]        i_cursor_x,
    input  logic signed [mcdd_pkg::POS_W-1:0]        i_cursor_y,
    input  logic [mcdd_pkg::MASK_W-1:0]              i_button_bits,
    input  logic                                     i_out_ready,
    output logic                                     o_out_valid,
    output logic [mcdd_pkg::MASK_W-1:0]              o_held_mask,
    output logic [mcdd_pkg::MASK_W-1:0]              o_pressed_mask,
    output logic [mcdd_pkg::MASK_W-1:0]              o_released_mask,
    output logic [mcdd_pkg::MASK_W-1:0]              o_dragging_mask,
    output logic [mcdd_pkg::MASK_W-1:0]              o_clicked_mask,
    output logic [mcdd_pkg::MASK_W-1:0]              o_double_clicked_mask,
    output logic signed [mcdd_pkg::VEC_W-1:0]        o_drag_dx,
    output logic signed [mcdd_pkg::VEC_W-1:0]        o_drag_dy
);

    localparam int NB  = BUTTON_COUNT;
    localparam int PW  = $clog2(HISTORY_DEPTH);
    localparam int AW  = PW;
    localparam int WW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SW  = WW + 1;
    localparam int SQN = 2 * NB;
    localparam int IW  = $clog2(SQN + 1);
    localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int POS_W  = mcdd_pkg::POS_W;
    localparam int VEC_W  = mcdd_pkg::VEC_W;
    localparam int SQ_W   = mcdd_pkg::SQ_W;
    localparam int LEN2_W = mcdd_pkg::LEN2_W;
    localparam int MASK_W = mcdd_pkg::MASK_W;

    // frame sample
    logic signed [POS_W-1:0] r_px, r_py;
    logic [NB-1:0]           r_cur, r_was, r_last;
    logic [NB-1:0]           held, down, up;

    // history
    logic [NB-1:0] r_mem [HISTORY_DEPTH];
    logic [PW-1:0] r_wr;
    logic [WW-1:0] r_fill;

    // per-button drag state
    logic signed [POS_W-1:0] r_org_x [NB];
    logic signed [POS_W-1:0] r_org_y [NB];
    logic signed [VEC_W-1:0] r_vx [NB];
    logic signed [VEC_W-1:0] r_vy [NB];
    logic [NB-1:0]           r_drag_flag;
    logic [LEN2_W-1:0]       r_d2 [NB];

    // squarer
    logic [IW-1:0]             r_sq_idx;
    logic                      sq_last;
    logic [BW-1:0]             sq_btn;
    logic                      sq_ax;
    logic signed [VEC_W-1:0]   sq_sel;
    logic signed [2*VEC_W-1:0] sq_full;
    logic [SQ_W-1:0]           r_prod;
    logic [SQ_W-1:0]           r_acc;
    logic [BW-1:0]             r_prod_btn;
    logic                      r_prod_ax;
    logic                      r_prod_go;
    logic                      rpt_hit;
    logic signed [VEC_W-1:0]   r_rdx, r_rdy;

    // scan
    logic [NB-1:0] r_dragging, r_near;
    logic [AW-1:0] r_age;
    logic [PW-1:0] r_rd_ptr;
    logic [SW-1:0] st_sum;
    logic [PW-1:0] scan_start;
    logic          scan_more;
    logic          scan_issue;
    logic [NB-1:0] r_rd_data;
    logic          r_rd_live;
    logic          r_rd_go;
    logic [NB-1:0] dn;
    logic [NB-1:0] r_sd, r_su, r_found;

    // result
    logic [NB-1:0] f_drag, f_click, f_dbl;
    logic          r_out_valid;
    logic [MASK_W-1:0] r_held_m, r_press_m, r_rel_m, r_drag_m, r_click_m, r_dbl_m;
    logic signed [VEC_W-1:0] r_out_dx, r_out_dy;

    assign held = r_cur;
    assign down = r_cur & ~r_was;
    assign up   = ~r_cur & r_was;

    assign sq_last = (r_sq_idx == IW'(SQN));
    assign sq_btn  = BW'(r_sq_idx >> 1);
    assign sq_ax   = r_sq_idx[0];
    assign sq_sel  = sq_ax ? r_vy[sq_btn] : r_vx[sq_btn];
    assign sq_full = sq_sel * sq_sel;
    assign rpt_hit = (i_cfg.rpt != mcdd_pkg::RPT_NONE) &&
                     (4'(sq_btn) == 4'(i_cfg.rpt));

    // oldest scanned entry sits at age win-1
    assign st_sum     = SW'(r_wr) + SW'(HISTORY_DEPTH) - SW'(i_win);
    assign scan_start = (st_sum >= SW'(HISTORY_DEPTH)) ? PW'(st_sum - SW'(HISTORY_DEPTH))
                                                       : PW'(st_sum);
    assign scan_more  = (int'(r_age) >= mcdd_pkg::WIN_MIN);
    assign scan_issue = i_cmd.scan && scan_more;
    assign dn         = {NB{r_rd_live}} & r_rd_data;

    always_comb begin
        f_drag  = '0;
        f_click = '0;
        f_dbl   = '0;
        for (int b = 0; b < NB; b++) begin
            if (up[b]) begin
                f_drag[b]  = r_dragging[b];
                f_click[b] = !r_dragging[b];
                f_dbl[b]   = !r_dragging[b] && r_near[b] && r_found[b];
            end else if (held[b] && !down[b]) begin
                f_drag[b]  = r_dragging[b];
            end
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wr] <= NB'(i_button_bits);
        end
        if (scan_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_wr        <= '0;
            r_fill      <= '0;
            r_drag_flag <= '0;
            r_prod_go   <= 1'b0;
            r_rd_go     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= NB'(i_button_bits);
                r_wr   <= (r_wr == PW'(HISTORY_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                if (r_fill != WW'(HISTORY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            r_prod_go <= i_cmd.sq && !sq_last;
            r_rd_go   <= scan_issue;
            if (i_cmd.fin) begin
                r_drag_flag <= f_drag;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px  <= i_cursor_x;
            r_py  <= i_cursor_y;
            r_cur <= NB'(i_button_bits);
            r_was <= r_last;
        end

        if (i_cmd.vec) begin
            for (int b = 0; b < NB; b++) begin
                if (!held[b] && !up[b]) begin
                    r_vx[b] <= '0;
                    r_vy[b] <= '0;
                end else if (down[b]) begin
                    r_org_x[b] <= r_px;
                    r_org_y[b] <= r_py;
                    r_vx[b]    <= '0;
                    r_vy[b]    <= '0;
                end else begin
                    r_vx[b] <= VEC_W'(r_px) - VEC_W'(r_org_x[b]);
                    r_vy[b] <= VEC_W'(r_py) - VEC_W'(r_org_y[b]);
                end
            end
            r_sq_idx <= '0;
            r_rdx    <= '0;
            r_rdy    <= '0;
        end else if (i_cmd.sq && !sq_last) begin
            r_sq_idx   <= r_sq_idx + 1'b1;
            r_prod     <= sq_full[SQ_W-1:0];
            r_prod_btn <= sq_btn;
            r_prod_ax  <= sq_ax;
            if (rpt_hit) begin
                if (sq_ax) begin
                    r_rdy <= sq_sel;
                end else begin
                    r_rdx <= sq_sel;
                end
            end
        end

        // x square waits in the accumulator for the y square
        if (r_prod_go) begin
            if (r_prod_ax) begin
                r_d2[r_prod_btn] <= LEN2_W'(r_acc) + LEN2_W'(r_prod);
            end else begin
                r_acc <= r_prod;
            end
        end

        if (i_cmd.eval) begin
            for (int b = 0; b < NB; b++) begin
                r_dragging[b] <= r_drag_flag[b] ||
                                 (held[b] && (r_d2[b] >= LEN2_W'(i_cfg.thr2)));
                r_near[b]     <= (r_d2[b] < LEN2_W'(i_cfg.dcd2));
            end
            r_age    <= AW'(i_win - 1'b1);
            r_rd_ptr <= scan_start;
            r_sd     <= '0;
            r_su     <= '0;
            r_found  <= '0;
        end else begin
            if (scan_issue) begin
                r_rd_live <= (WW'(r_age) < r_fill);
                r_age     <= r_age - 1'b1;
                r_rd_ptr  <= (r_rd_ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            // press, release, press seen oldest first
            if (r_rd_go) begin
                for (int b = 0; b < NB; b++) begin
                    if (!r_sd[b] && dn[b]) begin
                        r_sd[b] <= 1'b1;
                    end else if (r_sd[b] && !r_su[b] && !dn[b]) begin
                        r_su[b] <= 1'b1;
                    end else if (r_su[b] && dn[b]) begin
                        r_found[b] <= 1'b1;
                    end
                end
            end
        end

        if (i_cmd.fin) begin
            r_held_m  <= MASK_W'(held);
            r_press_m <= MASK_W'(down);
            r_rel_m   <= MASK_W'(up);
            r_drag_m  <= MASK_W'(f_drag);
            r_click_m <= MASK_W'(f_click);
            r_dbl_m   <= MASK_W'(f_dbl);
            r_out_dx  <= r_rdx;
            r_out_dy  <= r_rdy;
        end
    end

    assign o_sts.sq_done   = sq_last;
    assign o_sts.scan_more = scan_more;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_held_mask           = r_held_m;
    assign o_pressed_mask        = r_press_m;
    assign o_released_mask       = r_rel_m;
    assign o_dragging_mask       = r_drag_m;
    assign o_clicked_mask        = r_click_m;
    assign o_double_clicked_mask = r_dbl_m;
    assign o_drag_dx             = r_out_dx;
    assign o_drag_dy             = r_out_dy;

endmodule

// ----- tb/tb_top.sv -----
// testbench for mouse_click_drag_detector_core: directed and random mouse frames under
// several register settings, each result checked against a gesture predictor
// depends on mcdd_pkg and the rtl under hdl/
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH   = mcdd_pkg::HISTORY_DEPTH_DEF;
    localparam int BUTTONS      = mcdd_pkg::BUTTON_COUNT_DEF;
    localparam int POS_W        = mcdd_pkg::POS_W;
    localparam int VEC_W        = mcdd_pkg::VEC_W;
    localparam int MASK_W       = mcdd_pkg::MASK_W;
    localparam int DIST_W       = mcdd_pkg::DIST_W;
    localparam int WIN_CFG_W    = mcdd_pkg::WIN_CFG_W;
    localparam int RPT_W        = mcdd_pkg::RPT_W;
    localparam int CFG_IDX_W    = mcdd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = mcdd_pkg::CFG_DATA_W;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 145;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;

    localparam logic [2:0] FLAG_DRAG   = 3'b001;
    localparam logic [2:0] FLAG_CLICK  = 3'b010;
    localparam logic [2:0] FLAG_DOUBLE = 3'b100;

    typedef struct packed {
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] dragging;
        logic [MASK_W-1:0] clicked;
        logic [MASK_W-1:0] dbl_clicked;
        logic [VEC_W-1:0]  dx;
        logic [VEC_W-1:0]  dy;
    } t_gesture_report;

    class t_gesture_tracker;
        logic [MASK_W-1:0]    history [HIST_DEPTH];
        int                   wr_ptr;
        int                   origin_x [BUTTONS];
        int                   origin_y [BUTTONS];
        int                   vec_x [BUTTONS];
        int                   vec_y [BUTTONS];
        logic [2:0]           flags [BUTTONS];
        logic [DIST_W-1:0]    drag_thr;
        logic [DIST_W-1:0]    dc_dist;
        logic [WIN_CFG_W-1:0] dc_win;
        logic [RPT_W-1:0]     rpt_btn;
        t_gesture_report      pending_reports [$];
        int                   checked;
        int                   failures;

        function new();
            for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
            for (int b = 0; b < BUTTONS; b++) begin
                origin_x[b] = 0;
                origin_y[b] = 0;
                vec_x[b]    = 0;
                vec_y[b]    = 0;
                flags[b]    = '0;
            end
            wr_ptr   = 0;
            drag_thr = mcdd_pkg::THR_RESET;
            dc_dist  = mcdd_pkg::DCD_RESET;
            dc_win   = mcdd_pkg::WIN_RESET;
            rpt_btn  = mcdd_pkg::RPT_RESET;
            checked  = 0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                mcdd_pkg::CFG_DRAG_THR: drag_thr = data;
                mcdd_pkg::CFG_DC_DIST:  dc_dist  = data;
                mcdd_pkg::CFG_DC_WIN:   dc_win   = data[WIN_CFG_W-1:0];
                mcdd_pkg::CFG_RPT_BTN:  rpt_btn  = data[RPT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [MASK_W-1:0] hist_at(int age);
            return history[(wr_ptr + HIST_DEPTH - 1 - age) % HIST_DEPTH];
        endfunction

        // advances the gesture state by one frame and queues the expected result
        function void note_frame(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                 logic [MASK_W-1:0] bits);
            t_gesture_report   rep;
            int                thr, dcd, win;
            longint            thr2, dcd2, d2;
            logic [MASK_W-1:0] cur, prev;
            logic              held, was, down, up, dragging, seen_down, seen_up, dn;
            logic [2:0]        f;

            rep  = '0;
            thr  = (drag_thr > mcdd_pkg::DIST_MAX) ? int'(mcdd_pkg::DIST_MAX) : int'(drag_thr);
            dcd  = (dc_dist > mcdd_pkg::DIST_MAX) ? int'(mcdd_pkg::DIST_MAX) : int'(dc_dist);
            win  = int'(dc_win);
            if (win < mcdd_pkg::WIN_MIN) win = mcdd_pkg::WIN_MIN;
            if (win > HIST_DEPTH) win = HIST_DEPTH;
            thr2 = longint'(thr) * thr;
            dcd2 = longint'(dcd) * dcd;

            history[wr_ptr] = bits;
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
            cur  = hist_at(0);
            prev = hist_at(1);

            for (int b = 0; b < BUTTONS; b++) begin
                held = cur[b];
                was  = prev[b];
                down = held && !was;
                up   = !held && was;

                if (!held && !up) begin
                    vec_x[b] = 0;
                    vec_y[b] = 0;
                end else begin
                    if (down) begin
                        origin_x[b] = int'(px);
                        origin_y[b] = int'(py);
                    end
                    vec_x[b] = int'(px) - origin_x[b];
                    vec_y[b] = int'(py) - origin_y[b];
                end

                d2 = longint'(vec_x[b]) * vec_x[b] + longint'(vec_y[b]) * vec_y[b];
                dragging = ((flags[b] & FLAG_DRAG) != 0) || (held && d2 >= thr2);
                f = dragging ? FLAG_DRAG : 3'b000;
                if (up) begin
                    if (!dragging) begin
                        f = f | FLAG_CLICK;
                        seen_down = 1'b0;
                        seen_up   = 1'b0;
                        // oldest entry first, the two newest frames stay out of the scan
                        for (int age = win - 1; age >= 2; age--) begin
                            dn = 1'(hist_at(age) >> b);
                            if (!seen_down && dn)
                                seen_down = 1'b1;
                            else if (seen_down && !seen_up && !dn)
                                seen_up = 1'b1;
                            else if (seen_up && dn && d2 < dcd2)
                                f = f | FLAG_DOUBLE;
                        end
                    end
                end else if (!held || down) begin
                    f = 3'b000;
                end
                flags[b] = f;

                rep.held[b]        = held;
                rep.pressed[b]     = down;
                rep.released[b]    = up;
                rep.dragging[b]    = (f & FLAG_DRAG) != 0;
                rep.clicked[b]     = (f & FLAG_CLICK) != 0;
                rep.dbl_clicked[b] = (f & FLAG_DOUBLE) != 0;
            end

            if (int'(rpt_btn) < BUTTONS) begin
                rep.dx = VEC_W'(vec_x[rpt_btn]);
                rep.dy = VEC_W'(vec_y[rpt_btn]);
            end
            pending_reports.push_back(rep);
        endfunction

        function void show(string tag, t_gesture_report r);
            $display("  %s held=%b pressed=%b released=%b dragging=%b clicked=%b dbl=%b",
                     tag, r.held, r.pressed, r.released, r.dragging, r.clicked,
                     r.dbl_clicked);
            $display("  %s dx=%0d dy=%0d", tag, $signed(r.dx), $signed(r.dy));
        endfunction

        function void check_report(t_gesture_report got);
            t_gesture_report want;
            checked++;
            if (pending_reports.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN) begin
                    $display("result %0d arrived with no request outstanding", checked);
                    show("actual  ", got);
                end
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= MAX_SHOWN) begin
                    $display("mismatch on result %0d", checked);
                    show("expected", want);
                    show("actual  ", got);
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_cursor_x = '0;
    logic signed [POS_W-1:0] i_cursor_y = '0;
    logic [MASK_W-1:0]       i_button_bits = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [MASK_W-1:0]       o_held_mask;
    logic [MASK_W-1:0]       o_pressed_mask;
    logic [MASK_W-1:0]       o_released_mask;
    logic [MASK_W-1:0]       o_dragging_mask;
    logic [MASK_W-1:0]       o_clicked_mask;
    logic [MASK_W-1:0]       o_double_clicked_mask;
    logic signed [VEC_W-1:0] o_drag_dx;
    logic signed [VEC_W-1:0] o_drag_dy;

    t_gesture_tracker tracker = new();
    bit               calm = 1'b0;

    mouse_click_drag_detector_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_cursor_x            (i_cursor_x),
        .i_cursor_y            (i_cursor_y),
        .i_button_bits         (i_button_bits),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_held_mask           (o_held_mask),
        .o_pressed_mask        (o_pressed_mask),
        .o_released_mask       (o_released_mask),
        .o_dragging_mask       (o_dragging_mask),
        .o_clicked_mask        (o_clicked_mask),
        .o_double_clicked_mask (o_double_clicked_mask),
        .o_drag_dx             (o_drag_dx),
        .o_drag_dy             (o_drag_dy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one request per call, sometimes with a random gap in front of it (never once calm is set)
    task automatic send_frame(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                              input logic [MASK_W-1:0] bits);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cursor_x    <= x;
        i_cursor_y    <= y;
        i_button_bits <= bits;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_frame(x, y, bits);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.set_reg(idx, data);
    endtask

    // registers change only once the block has drained
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] dcd,
                                  input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] rpt);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(mcdd_pkg::CFG_DRAG_THR, thr);
        write_reg(mcdd_pkg::CFG_DC_DIST, dcd);
        write_reg(mcdd_pkg::CFG_DC_WIN, win);
        write_reg(mcdd_pkg::CFG_RPT_BTN, rpt);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int clamp_pos(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_report({o_held_mask, o_pressed_mask, o_released_mask, o_dragging_mask,
                                  o_clicked_mask, o_double_clicked_mask, o_drag_dx, o_drag_dy});
    end

    initial begin : result_sink
        int stall;
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && tracker.checked >= HOLD_AFTER) begin
                // long hold-off so the block fills up and stops taking requests
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 5);
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int                cur_x, cur_y, step, r;
        logic [MASK_W-1:0] cur_bits, flip;

        cur_x    = 0;
        cur_y    = 0;
        cur_bits = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at reset settings
        send_frame(16'sd0, 16'sd0, 3'b000);
        // full-range drag of the left button
        send_frame(-16'sd32768, -16'sd32768, 3'b001);
        send_frame(16'sd32767, 16'sd32767, 3'b001);
        send_frame(16'sd32767, 16'sd32767, 3'b000);
        // right button just below, then exactly at the threshold
        send_frame(16'sd0, 16'sd0, 3'b010);
        send_frame(16'sd19, 16'sd0, 3'b010);
        send_frame(16'sd20, 16'sd0, 3'b010);
        send_frame(16'sd20, 16'sd0, 3'b000);
        // middle button diagonal of length exactly the threshold
        send_frame(-16'sd5, 16'sd7, 3'b100);
        send_frame(16'sd7, 16'sd23, 3'b100);
        send_frame(16'sd7, 16'sd23, 3'b000);
        // left double click with a small movement
        send_frame(16'sd50, 16'sd50, 3'b001);
        send_frame(16'sd50, 16'sd50, 3'b000);
        send_frame(16'sd51, 16'sd50, 3'b001);
        send_frame(16'sd51, 16'sd51, 3'b001);
        send_frame(16'sd52, 16'sd51, 3'b000);
        // all buttons double click at the corner of most negative x and most positive y
        send_frame(-16'sd32768, 16'sd32767, 3'b111);
        send_frame(-16'sd32768, 16'sd32767, 3'b000);
        send_frame(-16'sd32767, 16'sd32767, 3'b111);
        send_frame(-16'sd32767, 16'sd32766, 3'b111);
        send_frame(-16'sd32767, 16'sd32766, 3'b000);
        // release of one button while another keeps going and a third is pressed
        send_frame(16'sd1000, -16'sd1000, 3'b011);
        send_frame(16'sd1003, -16'sd998, 3'b110);
        send_frame(16'sd1003, -16'sd998, 3'b000);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(mcdd_pkg::THR_RESET, mcdd_pkg::DCD_RESET,
                                  CFG_DATA_W'(mcdd_pkg::WIN_RESET),
                                  CFG_DATA_W'(mcdd_pkg::RPT_RESET));
                1: apply_settings(7'd0, 7'd0, 7'd0, CFG_DATA_W'(mcdd_pkg::RPT_NONE));
                2: apply_settings(7'd127, 7'd127, 7'd31, 7'd1);
                3: apply_settings(mcdd_pkg::DIST_MAX, mcdd_pkg::DIST_MAX, 7'd16, 7'd2);
                4: apply_settings(7'd1, 7'd5, 7'd2, 7'd0);
                default: apply_settings(CFG_DATA_W'($urandom_range(0, 127)),
                                        CFG_DATA_W'($urandom_range(0, 127)),
                                        CFG_DATA_W'($urandom_range(0, 127)),
                                        CFG_DATA_W'($urandom_range(0, 127)));
            endcase
            if (ph == PHASES - 1)
                calm = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // noise: anywhere on the plane, any buttons
                    cur_x    = int'($urandom_range(0, 65535)) - 32768;
                    cur_y    = int'($urandom_range(0, 65535)) - 32768;
                    cur_bits = MASK_W'($urandom_range(0, 7));
                end else begin
                    flip = '0;
                    for (int b = 0; b < BUTTONS; b++)
                        if ($urandom_range(0, 9) < 3)
                            flip[b] = 1'b1;
                    cur_bits = cur_bits ^ flip;
                    step  = (r < 12) ? 2000 : (r < 40) ? 25 : 3;
                    cur_x = clamp_pos(cur_x + int'($urandom_range(0, 2 * step)) - step);
                    cur_y = clamp_pos(cur_y + int'($urandom_range(0, 2 * step)) - step);
                end
                send_frame(POS_W'(cur_x), POS_W'(cur_y), cur_bits);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.failures += tracker.pending_reports.size();
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
